[design/crt_pkg.sv]
// Shared constants, codes and control types for the code range table.
// Used by the channel interfaces, the controller, the datapath and the top level.
package crt_pkg;

   localparam int ENTRIES   = 64;
   localparam int ADDR_BITS = 48;

   localparam int MODE_W   = 2;
   localparam int ADDR_W   = 48;
   localparam int SIZE_W   = 24;
   localparam int SEL_W    = 6;
   localparam int STATUS_W = 2;

   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int LINK_BITS = $clog2(ENTRIES + 1);

   localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
      ADDR_W'((64'(1) << ADDR_BITS) - 64'(1));

   localparam logic [LINK_BITS-1:0] LINK_NULL = LINK_BITS'(ENTRIES);
   localparam logic [IDX_BITS-1:0]  LAST_IDX  = IDX_BITS'(ENTRIES - 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_FIND  = 2'd2,
      MODE_MOVE  = 2'd3
   } crt_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } crt_status_type;

   typedef enum logic [2:0] {
      RES_FULL,
      RES_MISS,
      RES_ALLOC,
      RES_HIT,
      RES_MOVE
   } crt_res_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ALLOC_COMMIT,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_SCAN_DONE,
      ST_MOVE_COMMIT,
      ST_RESULT
   } crt_state_type;

   typedef struct packed {
      logic             load_req;
      logic             scan_step;
      logic             link_read;
      logic             alloc_commit;
      logic             free_commit;
      logic             move_read;
      logic             move_commit;
      logic             res_load;
      crt_res_kind_type res_kind;
      logic             out_load;
   } crt_cmd_type;

   typedef struct packed {
      crt_mode_type mode;
      logic         head_null;
      logic         move_ok;
      logic         scan_last;
      logic         hit;
      logic         out_free;
   } crt_stat_type;

endpackage

[design/crt_if.sv]
// Valid/ready channel interfaces for request and response items.
// Depends on crt_pkg for the field widths.
interface crt_req_if import crt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [ADDR_W-1:0] address;
   logic [SIZE_W-1:0] region_size;
   logic [SEL_W-1:0]  entry_select;

   modport source (output valid, mode, address, region_size, entry_select, input ready);
   modport sink   (input valid, mode, address, region_size, entry_select, output ready);
endinterface

interface crt_rsp_if import crt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SEL_W-1:0]    entry_index;
   logic [ADDR_W-1:0]   entry_start;
   logic [SIZE_W-1:0]   entry_size;

   modport source (output valid, status, entry_index, entry_start, entry_size, input ready);
   modport sink   (input valid, status, entry_index, entry_start, entry_size, output ready);
endinterface

[design/code_range_table_core.sv]
// Code range table: a pool of ENTRIES code regions (start, size) with a LIFO free list.
// Allocate and move pass dispatch, a commit state and the result state; when the table
// is full or the entry to move is not in use, dispatch goes straight to result. Free
// and find walk every entry through the start and size RAM read ports, one entry per
// cycle, then scan tail and scan done. One item is worked on at a time; the next
// request is taken while the previous result still waits in the output register.
// On overlapping regions, find and free report the highest matching entry index.
// Depends on crt_pkg, crt_if, crt_ctrl and crt_datapath.
module code_range_table_core
   import crt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   crt_req_if.sink   req_ch,
   crt_rsp_if.source rsp_ch
);

   crt_cmd_type  cmd;
   crt_stat_type stat;
   logic         ready;

   crt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   crt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_mode         (req_ch.mode),
      .req_address      (req_ch.address),
      .req_region_size  (req_ch.region_size),
      .req_entry_select (req_ch.entry_select),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ch           (rsp_ch)
   );

   assign req_ch.ready = ready;

endmodule

[design/crt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module crt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/crt_ctrl.sv]
// Sequencing state machine for the code range table.
// Depends on crt_pkg; drives crt_datapath through crt_cmd_type.
module crt_ctrl
   import crt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  crt_stat_type stat,
   output crt_cmd_type  cmd
);

   crt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.res_kind = RES_MISS;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.mode)
               MODE_ALLOC: begin
                  if (stat.head_null) begin
                     cmd.res_load = 1'b1;
                     cmd.res_kind = RES_FULL;
                     state_in     = ST_RESULT;
                  end else begin
                     cmd.link_read = 1'b1;
                     state_in      = ST_ALLOC_COMMIT;
                  end
               end
               MODE_FREE, MODE_FIND: begin
                  state_in = ST_SCAN;
               end
               MODE_MOVE: begin
                  if (stat.move_ok) begin
                     cmd.move_read = 1'b1;
                     state_in      = ST_MOVE_COMMIT;
                  end else begin
                     cmd.res_load = 1'b1;
                     cmd.res_kind = RES_MISS;
                     state_in     = ST_RESULT;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ALLOC_COMMIT: begin
            cmd.alloc_commit = 1'b1;
            cmd.res_load     = 1'b1;
            cmd.res_kind     = RES_ALLOC;
            state_in         = ST_RESULT;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_SCAN_TAIL;
            end
         end
         ST_SCAN_TAIL: begin
            // last entry is compared in this cycle
            state_in = ST_SCAN_DONE;
         end
         ST_SCAN_DONE: begin
            cmd.res_load = 1'b1;
            if (stat.hit) begin
               cmd.res_kind    = RES_HIT;
               cmd.free_commit = (stat.mode == MODE_FREE);
            end else begin
               cmd.res_kind = RES_MISS;
            end
            state_in = ST_RESULT;
         end
         ST_MOVE_COMMIT: begin
            cmd.move_commit = 1'b1;
            cmd.res_load    = 1'b1;
            cmd.res_kind    = RES_MOVE;
            state_in        = ST_RESULT;
         end
         ST_RESULT: begin
            // hold until the output register can take the item
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[design/crt_datapath.sv]
// Datapath of the code range table: entry stores, free list, range scan and output register.
// Depends on crt_pkg, crt_rsp_if and crt_ram.
module crt_datapath
   import crt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [SIZE_W-1:0] req_region_size,
   input  logic [SEL_W-1:0]  req_entry_select,
   input  crt_cmd_type       cmd,
   output crt_stat_type      stat,
   crt_rsp_if.source         rsp_ch
);

   // request registers
   crt_mode_type      mode_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [SEL_W-1:0]  sel_ff;

   // free list and entry flags
   logic [LINK_BITS-1:0] head_ff;
   logic [ENTRIES-1:0]   in_use_ff;
   logic [ENTRIES-1:0]   link_written_ff;
   logic [IDX_BITS-1:0]  link_idx_ff;
   logic                 link_fresh_ff;

   // scan
   logic [IDX_BITS-1:0] scan_cnt_ff;
   logic                eval_valid_ff;
   logic [IDX_BITS-1:0] eval_idx_ff;
   logic                hit_ff;
   logic [IDX_BITS-1:0] hit_idx_ff;
   logic [ADDR_W-1:0]   hit_start_ff;
   logic [SIZE_W-1:0]   hit_size_ff;

   // result and output registers
   crt_status_type      res_status_ff;
   logic [IDX_BITS-1:0] res_idx_ff;
   logic [ADDR_W-1:0]   res_start_ff;
   logic [SIZE_W-1:0]   res_size_ff;
   logic                rsp_valid_ff;
   crt_status_type      rsp_status_ff;
   logic [SEL_W-1:0]    rsp_idx_ff;
   logic [ADDR_W-1:0]   rsp_start_ff;
   logic [SIZE_W-1:0]   rsp_size_ff;

   logic [IDX_BITS-1:0]  head_idx;
   logic [IDX_BITS-1:0]  sel_idx;
   logic                 sel_in_range;
   logic [LINK_BITS-1:0] link_rd;
   logic [LINK_BITS-1:0] link_val;
   logic [ADDR_W-1:0]    start_rd;
   logic [SIZE_W-1:0]    size_rd;
   logic [ADDR_W:0]      diff;
   logic                 covers;

   assign head_idx     = head_ff[IDX_BITS-1:0];
   assign sel_idx      = IDX_BITS'(sel_ff);
   assign sel_in_range = 32'(sel_ff) < 32'(ENTRIES);

   assign link_val = link_fresh_ff ? link_rd :
                     LINK_BITS'({1'b0, link_idx_ff}) + LINK_BITS'(1);

   // start <= address and (address - start) < size
   assign diff   = {1'b0, addr_ff} - {1'b0, start_rd};
   assign covers = !diff[ADDR_W] && (diff[ADDR_W-1:SIZE_W] == '0) &&
                   (diff[SIZE_W-1:0] < size_rd);

   crt_ram #(.WIDTH(ADDR_W), .DEPTH(ENTRIES)) u_start_ram (
      .clock   (clock),
      .wr_en   (cmd.alloc_commit || cmd.move_commit),
      .wr_addr (cmd.alloc_commit ? head_idx : sel_idx),
      .wr_data (addr_ff),
      .rd_en   (cmd.scan_step),
      .rd_addr (scan_cnt_ff),
      .rd_data (start_rd)
   );

   crt_ram #(.WIDTH(SIZE_W), .DEPTH(ENTRIES)) u_size_ram (
      .clock   (clock),
      .wr_en   (cmd.alloc_commit),
      .wr_addr (head_idx),
      .wr_data (size_ff),
      .rd_en   (cmd.scan_step || cmd.move_read),
      .rd_addr (cmd.move_read ? sel_idx : scan_cnt_ff),
      .rd_data (size_rd)
   );

   crt_ram #(.WIDTH(LINK_BITS), .DEPTH(ENTRIES)) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.free_commit),
      .wr_addr (hit_idx_ff),
      .wr_data (head_ff),
      .rd_en   (cmd.link_read),
      .rd_addr (head_idx),
      .rd_data (link_rd)
   );

   // request capture, scan counter and link read bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= crt_mode_type'(req_mode);
         addr_ff <= req_address & ADDR_MASK;
         size_ff <= req_region_size;
         sel_ff  <= req_entry_select;
      end
      if (cmd.load_req) begin
         scan_cnt_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_cnt_ff <= scan_cnt_ff + IDX_BITS'(1);
      end
      if (cmd.scan_step) begin
         eval_idx_ff <= scan_cnt_ff;
      end
      if (cmd.link_read) begin
         link_idx_ff   <= head_idx;
         link_fresh_ff <= link_written_ff[head_idx];
      end
      if (eval_valid_ff && in_use_ff[eval_idx_ff] && covers) begin
         hit_idx_ff   <= eval_idx_ff;
         hit_start_ff <= start_rd;
         hit_size_ff  <= size_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_valid_ff <= 1'b0;
         hit_ff        <= 1'b0;
      end else begin
         eval_valid_ff <= cmd.scan_step;
         if (cmd.load_req) begin
            hit_ff <= 1'b0;
         end else if (eval_valid_ff && in_use_ff[eval_idx_ff] && covers) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // free list and in-use marks
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff         <= '0;
         in_use_ff       <= '0;
         link_written_ff <= '0;
      end else begin
         if (cmd.alloc_commit) begin
            in_use_ff[head_idx] <= 1'b1;
            head_ff             <= link_val;
         end
         if (cmd.free_commit) begin
            in_use_ff[hit_idx_ff]       <= 1'b0;
            link_written_ff[hit_idx_ff] <= 1'b1;
            head_ff                     <= LINK_BITS'({1'b0, hit_idx_ff});
         end
      end
   end

   // result of the current item
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         unique case (cmd.res_kind)
            RES_FULL: begin
               res_status_ff <= STATUS_FULL;
               res_idx_ff    <= '0;
               res_start_ff  <= '0;
               res_size_ff   <= '0;
            end
            RES_ALLOC: begin
               res_status_ff <= STATUS_OK;
               res_idx_ff    <= head_idx;
               res_start_ff  <= addr_ff;
               res_size_ff   <= size_ff;
            end
            RES_HIT: begin
               res_status_ff <= STATUS_OK;
               res_idx_ff    <= hit_idx_ff;
               res_start_ff  <= hit_start_ff;
               res_size_ff   <= hit_size_ff;
            end
            RES_MOVE: begin
               res_status_ff <= STATUS_OK;
               res_idx_ff    <= sel_idx;
               res_start_ff  <= addr_ff;
               res_size_ff   <= size_rd;
            end
            default: begin
               res_status_ff <= STATUS_MISS;
               res_idx_ff    <= '0;
               res_start_ff  <= '0;
               res_size_ff   <= '0;
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_idx_ff    <= SEL_W'(res_idx_ff);
         rsp_start_ff  <= res_start_ff;
         rsp_size_ff   <= res_size_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_index = rsp_idx_ff;
   assign rsp_ch.entry_start = rsp_start_ff;
   assign rsp_ch.entry_size  = rsp_size_ff;

   assign stat.mode      = mode_ff;
   assign stat.head_null = (head_ff == LINK_NULL);
   assign stat.move_ok   = sel_in_range && in_use_ff[sel_idx];
   assign stat.scan_last = (scan_cnt_ff == LAST_IDX);
   assign stat.hit       = hit_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ch.ready;

endmodule

[tb/code_range_table_core_tb.sv]
// Self-checking testbench for code_range_table_core: drives allocate, free, find and move
// items through the request channel and checks every response against a behavioral table.
// Depends on crt_pkg, the crt_req_if/crt_rsp_if interfaces and the code_range_table_core RTL.
module code_range_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crt_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 80;
   localparam int MAX_PRINTED  = 100;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SEL_W-1:0]    index;
      logic [ADDR_W-1:0]   start_addr;
      logic [SIZE_W-1:0]   region_len;
   } table_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   crt_req_if req_ch ();
   crt_rsp_if rsp_ch ();

   code_range_table_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // behavioral copy of the region table
   logic [ADDR_W-1:0]    tbl_start [ENTRIES];
   logic [SIZE_W-1:0]    tbl_len   [ENTRIES];
   bit                   tbl_live  [ENTRIES];
   logic [LINK_BITS-1:0] tbl_link  [ENTRIES];
   logic [LINK_BITS-1:0] tbl_head;

   table_reply_type replies_due [$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int idle_cycles   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, what);
   endtask

   function automatic void clear_table_model();
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_start[i] = '0;
         tbl_len[i]   = '0;
         tbl_live[i]  = 1'b0;
         tbl_link[i]  = LINK_BITS'(i + 1);
      end
      tbl_head = '0;
   endfunction

   // highest live entry whose range holds addr, ENTRIES when none does
   function automatic int find_region(input logic [ADDR_W-1:0] addr);
      int hit = ENTRIES;
      for (int i = 0; i < ENTRIES; i++) begin
         if (tbl_live[i] && addr >= tbl_start[i] &&
             (addr - tbl_start[i]) < ADDR_W'(tbl_len[i])) hit = i;
      end
      return hit;
   endfunction

   function automatic table_reply_type reply_for(input logic [STATUS_W-1:0] st, input int e);
      table_reply_type r;
      r = '0;
      r.status = st;
      if (e < ENTRIES) begin
         r.index      = SEL_W'(e);
         r.start_addr = tbl_start[e];
         r.region_len = tbl_len[e];
      end
      return r;
   endfunction

   function automatic table_reply_type apply_table_op(input crt_mode_type mode,
                                                      input logic [ADDR_W-1:0] addr_in,
                                                      input logic [SIZE_W-1:0] len,
                                                      input logic [SEL_W-1:0] sel);
      logic [ADDR_W-1:0] addr;
      int                e;
      table_reply_type   r;
      addr = addr_in & ADDR_MASK;
      case (mode)
         MODE_ALLOC: begin
            if (tbl_head >= LINK_NULL) begin
               r = reply_for(STATUS_FULL, ENTRIES);
            end else begin
               e = int'(tbl_head);
               tbl_head = tbl_link[e];
               if (tbl_head > LINK_NULL) tbl_head = LINK_NULL;
               tbl_live[e]  = 1'b1;
               tbl_start[e] = addr;
               tbl_len[e]   = len;
               r = reply_for(STATUS_OK, e);
            end
         end
         MODE_FREE: begin
            e = find_region(addr);
            if (e >= ENTRIES) begin
               r = reply_for(STATUS_MISS, ENTRIES);
            end else begin
               r = reply_for(STATUS_OK, e);
               tbl_live[e] = 1'b0;
               tbl_link[e] = tbl_head;
               tbl_head    = LINK_BITS'(e);
            end
         end
         MODE_FIND: begin
            e = find_region(addr);
            r = reply_for(e < ENTRIES ? STATUS_OK : STATUS_MISS, e);
         end
         default: begin
            if (int'(sel) >= ENTRIES || !tbl_live[sel]) begin
               r = reply_for(STATUS_MISS, ENTRIES);
            end else begin
               tbl_start[sel] = addr;
               r = reply_for(STATUS_OK, int'(sel));
            end
         end
      endcase
      return r;
   endfunction

   function automatic int live_count();
      int n = 0;
      for (int i = 0; i < ENTRIES; i++) if (tbl_live[i]) n++;
      return n;
   endfunction

   // random live entry, optionally one with a nonzero size; -1 when there is none
   function automatic int pick_live_entry(input bit need_len);
      int first = $urandom_range(ENTRIES - 1);
      int e;
      for (int k = 0; k < ENTRIES; k++) begin
         e = (first + k) % ENTRIES;
         if (tbl_live[e] && (!need_len || tbl_len[e] != '0)) return e;
      end
      return -1;
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'({$urandom, $urandom});
   endfunction

   // mostly a crowded window so that some regions overlap
   function automatic logic [ADDR_W-1:0] pick_start();
      int r = $urandom_range(99);
      if (r < 60) return 48'h7F00_0000_0000 + ADDR_W'($urandom_range(24'hFF_FFFF));
      if (r < 80) return rand_addr();
      if (r < 90) return ADDR_W'($urandom_range(65535));
      return '1 - ADDR_W'($urandom_range(4095));
   endfunction

   // zero-size regions can never be freed, so keep only a few of them live
   function automatic logic [SIZE_W-1:0] pick_len(input bit allow_zero);
      int                r = $urandom_range(99);
      int                zero_live = 0;
      logic [SIZE_W-1:0] v;
      for (int i = 0; i < ENTRIES; i++) if (tbl_live[i] && tbl_len[i] == '0) zero_live++;
      if (allow_zero && r < 2 && zero_live < 3) return '0;
      if (r < 65) return SIZE_W'($urandom_range(4096, 1));
      if (r < 85) begin
         v = SIZE_W'($urandom);
         if (v == '0) v = SIZE_W'(1);
         return v;
      end
      return '1;
   endfunction

   // hit the first, last or a middle byte of a live region, or just past its end, else a random address
   function automatic logic [ADDR_W-1:0] pick_lookup_addr();
      int                e = pick_live_entry(1'b0);
      int                len_v;
      logic [ADDR_W-1:0] off;
      if (e < 0 || $urandom_range(99) >= 80) return rand_addr();
      len_v = int'(tbl_len[e]);
      case ($urandom_range(3))
         0: off = '0;
         1: off = (len_v == 0) ? '0 : ADDR_W'(len_v - 1);
         2: off = (len_v == 0) ? '0 : ADDR_W'($urandom_range(len_v - 1));
         default: off = ADDR_W'(len_v);
      endcase
      return tbl_start[e] + off;
   endfunction

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic send_item(input crt_mode_type mode, input logic [ADDR_W-1:0] addr,
                            input logic [SIZE_W-1:0] len, input logic [SEL_W-1:0] sel);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= mode;
      req_ch.address      <= addr;
      req_ch.region_size  <= len;
      req_ch.entry_select <= sel;
      do @(posedge clock); while (!req_ch.ready);
      replies_due.insert(replies_due.size(), apply_table_op(mode, addr, len, sel));
      @(negedge clock);
   endtask

   task automatic send_random_op();
      int used = live_count();
      int alloc_pct;
      int r;
      int e;
      alloc_pct = (used < 16) ? 55 : ((used < 48) ? 35 : 20);
      r = $urandom_range(99);
      if (r < alloc_pct) begin
         send_item(MODE_ALLOC, pick_start(), pick_len(1'b1), SEL_W'($urandom));
      end else if (r < alloc_pct + 25) begin
         send_item(MODE_FREE, pick_lookup_addr(), SIZE_W'($urandom), SEL_W'($urandom));
      end else if (r < alloc_pct + 60) begin
         send_item(MODE_FIND, pick_lookup_addr(), SIZE_W'($urandom), SEL_W'($urandom));
      end else begin
         e = pick_live_entry(1'b0);
         if (e < 0 || $urandom_range(99) < 20) e = $urandom_range(ENTRIES - 1);
         send_item(MODE_MOVE, pick_start(), SIZE_W'($urandom), SEL_W'(e));
      end
   endtask

   // boundaries, empty table, zero size, overlap, move and LIFO reuse
   task automatic test_directed();
      send_item(MODE_FIND,  48'h0,              24'h0,      6'd0);
      send_item(MODE_FREE,  48'h1000,           24'h0,      6'd0);
      send_item(MODE_ALLOC, 48'h1000,           24'h100,    6'd0);
      send_item(MODE_ALLOC, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 6'd63);
      send_item(MODE_ALLOC, 48'h0,              24'h0,      6'd0);
      send_item(MODE_ALLOC, 48'h0,              24'h1,      6'd0);
      send_item(MODE_FIND,  48'h0,              24'h0,      6'd0);
      send_item(MODE_FIND,  48'h1000,           24'h0,      6'd0);
      send_item(MODE_FIND,  48'h10FF,           24'h0,      6'd0);
      send_item(MODE_FIND,  48'h1100,           24'h0,      6'd0);
      send_item(MODE_FIND,  48'h0FFF,           24'h0,      6'd0);
      send_item(MODE_FIND,  48'hFFFF_FFFF_FFFF, 24'h0,      6'd0);
      send_item(MODE_ALLOC, 48'h1080,           24'h200,    6'd0);
      send_item(MODE_FIND,  48'h1090,           24'h0,      6'd0);
      send_item(MODE_FIND,  48'h1010,           24'h0,      6'd0);
      send_item(MODE_MOVE,  48'h2000,           24'hFF_FFFF, 6'd4);
      send_item(MODE_FIND,  48'h1090,           24'h0,      6'd0);
      send_item(MODE_FREE,  48'h1090,           24'h0,      6'd0);
      send_item(MODE_MOVE,  48'h9000,           24'h0,      6'd0);
      send_item(MODE_MOVE,  48'h3000,           24'h0,      6'd2);
      send_item(MODE_ALLOC, 48'h5000,           24'h10,     6'd0);
      send_item(MODE_FIND,  48'h500F,           24'h0,      6'd0);
      send_item(MODE_FREE,  48'hFFFF_FFFF_FFFF, 24'h0,      6'd0);
      send_item(MODE_ALLOC, 48'hABCD_0000,      24'h80_0000, 6'd0);
      send_item(MODE_FIND,  48'h2000,           24'h0,      6'd0);
   endtask

   // fill every entry, hit the full case, then drain most of the table
   task automatic test_table_full();
      int e;
      int guard = 0;
      while (live_count() < ENTRIES)
         send_item(MODE_ALLOC, pick_start(), pick_len(1'b0), SEL_W'($urandom));
      repeat (2) send_item(MODE_ALLOC, pick_start(), pick_len(1'b0), SEL_W'($urandom));
      send_item(MODE_MOVE, pick_start(), SIZE_W'($urandom), SEL_W'(ENTRIES - 1));
      repeat (4) send_item(MODE_FIND, pick_lookup_addr(), SIZE_W'($urandom), SEL_W'($urandom));
      while (live_count() > 8 && guard < 400) begin
         e = pick_live_entry(1'b1);
         if (e < 0) break;
         send_item(MODE_FREE, tbl_start[e], SIZE_W'($urandom), SEL_W'($urandom));
         guard++;
      end
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int count);
      send_idle_pct = sender_idle;
      stall_pct     = receiver_stall;
      repeat (count) send_random_op();
   endtask

   always @(negedge clock) rsp_ch.ready <= !reset && ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin : check_replies
      table_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (replies_due.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = replies_due.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_ch.status, want.status));
            if (rsp_ch.entry_index !== want.index)
               report_mismatch($sformatf("entry_index got %0d want %0d",
                                         rsp_ch.entry_index, want.index));
            if (rsp_ch.entry_start !== want.start_addr)
               report_mismatch($sformatf("entry_start got %h want %h",
                                         rsp_ch.entry_start, want.start_addr));
            if (rsp_ch.entry_size !== want.region_len)
               report_mismatch($sformatf("entry_size got %h want %h",
                                         rsp_ch.entry_size, want.region_len));
         end
      end
   end

   // end the run when no item moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.mode         = MODE_ALLOC;
      req_ch.address      = '0;
      req_ch.region_size  = '0;
      req_ch.entry_select = '0;
      clear_table_model();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      send_idle_pct = 21;
      stall_pct     = 21;
      test_table_full();
      test_random_traffic(0, 0, 380);
      test_random_traffic(81, 0, 380);
      test_random_traffic(0, 81, 380);
      test_random_traffic(21, 21, 380);

      req_ch.valid <= 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
